// ===== sv/stbs_pkg.sv =====
// Package with the constants, codes and transaction types of the sorted table search block.
package stbs_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int ELEMENT_WIDTH = 64;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 64;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_COMPARE = 2'd1;

  typedef struct packed {
    logic               opcode;
    logic [INDEX_W-1:0] entry_index;
    logic [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } out_item_t;

endpackage

// ===== sv/sorted_table_binary_search.sv =====
// Top level of the sorted table search block: table memory, search sequencer and output register.
//
// The block holds a table of sorted elements in one synchronous memory and answers
// key searches on it. Input transactions arrive on in_valid/in_stall/in_data. A load
// transaction (opcode 0) writes item_value into the table at entry_index and gives no
// result. A search transaction (opcode 1) runs a binary search over the first
// entry_count elements and gives exactly one result transaction on
// out_valid/out_stall/out_data, with found and the matching position.
// A search makes one probe per cycle: the registered memory read is compared with the
// key, and the updated window selects the next read address in the same cycle. That
// memory loop sets the rate. When the search ends, the result is placed in the
// output register. in_stall is high while a search is in progress, so searches follow
// one another; loads are taken every cycle while no search is in progress.
// A finished result waits in the output register while the receiver stalls, and the
// block keeps accepting loads and the next search; that search holds its answer
// until the output register is free. The registers entry_count and signed_compare
// are written through cfg_we/cfg_index/cfg_wdata; the user must write them only while
// the block is idle, which the block itself does not enforce.
// Reset clears the registers, the sequencer and the output valid flag; the table
// contents are undefined until written.
module sorted_table_binary_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  stbs_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output stbs_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stbs_pkg::CFG_W-1:0]         cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_t;

  // The table itself, one write port and one registered read port.
  logic [stbs_pkg::ELEMENT_WIDTH-1:0] table_mem [stbs_pkg::TABLE_DEPTH];
  logic [stbs_pkg::ELEMENT_WIDTH-1:0] rdata_r;
  logic                               mem_we;
  logic [stbs_pkg::ADDR_W-1:0]        mem_waddr;
  logic [stbs_pkg::ADDR_W-1:0]        mem_raddr;

  // Configuration registers.
  logic [stbs_pkg::COUNT_W-1:0]       entry_count_r;
  logic                               signed_compare_r;

  // Search state: window bounds and the key in unsigned ordering form.
  state_t                             state_r, state_nxt;
  logic [stbs_pkg::COUNT_W-1:0]       lo_r, lo_nxt;
  logic [stbs_pkg::COUNT_W-1:0]       hi_r, hi_nxt;
  logic [stbs_pkg::ELEMENT_WIDTH-1:0] key_r, key_nxt;
  logic                               out_valid_r, out_valid_nxt;
  stbs_pkg::out_item_t                out_data_r, out_data_nxt;

  logic                               in_fire;
  logic                               out_free;
  logic [stbs_pkg::COUNT_W-1:0]       count_sat;
  logic [stbs_pkg::COUNT_W:0]         probe_sum;
  logic [stbs_pkg::COUNT_W-1:0]       probe_mid;
  logic [stbs_pkg::COUNT_W:0]         next_sum;
  logic [stbs_pkg::ELEMENT_WIDTH-1:0] sign_flip;
  logic [stbs_pkg::ELEMENT_WIDTH-1:0] elem_key;
  logic [stbs_pkg::ELEMENT_WIDTH-1:0] in_key;
  logic                               window_open;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Counts above the table depth are searched as a full table.
  assign count_sat = (entry_count_r > stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH)) ?
                     stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH) : entry_count_r;

  // Flipping the sign bit turns a two's-complement order into an unsigned one.
  assign sign_flip = {signed_compare_r, {(stbs_pkg::ELEMENT_WIDTH-1){1'b0}}};
  assign elem_key  = rdata_r ^ sign_flip;
  assign in_key    = in_data.item_value[stbs_pkg::ELEMENT_WIDTH-1:0] ^ sign_flip;

  // rdata_r holds the element at the midpoint of the current window.
  assign probe_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign probe_mid   = probe_sum[stbs_pkg::COUNT_W:1];
  assign window_open = (hi_r > lo_r);

  assign mem_waddr = in_data.entry_index[stbs_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r    <= '0;
      signed_compare_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stbs_pkg::REG_ENTRY_COUNT:    entry_count_r    <= cfg_wdata;
        stbs_pkg::REG_SIGNED_COMPARE: signed_compare_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == stbs_pkg::OP_SEARCH) begin
            lo_nxt    = '0;
            hi_nxt    = count_sat;
            key_nxt   = in_key;
            state_nxt = ST_PROBE;
          end else begin
            // Loads beyond the table depth are dropped.
            mem_we = ({1'b0, in_data.entry_index} <
                      (stbs_pkg::INDEX_W+1)'(stbs_pkg::TABLE_DEPTH));
          end
        end
      end
      ST_PROBE: begin
        if (!window_open || (elem_key == key_r)) begin
          // The search is over; wait here while the output register holds a stalled result.
          if (out_free) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.found    = window_open;
            out_data_nxt.position = window_open ?
                                    stbs_pkg::INDEX_W'(probe_mid) : '0;
            state_nxt             = ST_IDLE;
          end
        end else if (elem_key > key_r) begin
          hi_nxt = probe_mid;
        end else begin
          lo_nxt = probe_mid + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The next read address is the midpoint of the updated window, so a probe
  // completes every cycle. When the window is empty the read is unused.
  assign next_sum  = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mem_raddr = next_sum[stbs_pkg::ADDR_W:1];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= in_data.item_value[stbs_pkg::ELEMENT_WIDTH-1:0];
    end
    rdata_r <= table_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sv/stbs_checker.sv =====
// Port-level checker for the sorted table search block and its bind statement.
module stbs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input stbs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input stbs_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted search keeps the input side busy in the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == stbs_pkg::OP_SEARCH) |=> in_stall)
    else $error("input accepted during a search");

  // A miss reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> (out_data.position == '0))
    else $error("miss with nonzero position");

  // A load never creates a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == stbs_pkg::OP_LOAD) && !out_valid
    |=> !out_valid)
    else $error("result after a load");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
